### sv/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the stepper ramp generator
// Opcodes, register indexes, sequencer states and the queue entry layout.
// ----------------------------------------------------------------------------
package srg_pkg;

  // Step clock rate; the speed numerator is derived from it.
  localparam int unsigned TICKS_PER_SECOND = 1000000;
  localparam logic [63:0] SPEED_NUM = 64'(TICKS_PER_SECOND) << 24;

  localparam logic [31:0] INTERVAL_FLOOR = 32'd256;
  localparam logic [31:0] STS_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] RAMP_MAX       = 32'h7FFF_FFFF;

  localparam logic [6:0] MUL_STEPS = 7'd48;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_SETPOS = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ACCEL     = 2'd0,
    CFG_FIRST_INT = 2'd1,
    CFG_MIN_INT   = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STS_MUL,
    ST_STS_DIV,
    ST_STOP,
    ST_DECIDE,
    ST_DELTA,
    ST_SPEED,
    ST_EMIT
  } state_e;

  typedef enum logic {
    AR_MUL,
    AR_DIV
  } arith_op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

endpackage

### sv/srg_front.sv
// ----------------------------------------------------------------------------
// srg_front: request intake
// Decodes each incoming request and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module srg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic signed [31:0]   position_value_i,
  output logic                 q_valid_o,
  output srg_pkg::item_t       q_item_o,
  input  logic                 q_pop_i
);
  import srg_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  item_t      entry;

  assign entry.op    = op_e'(opcode_i);
  assign entry.value = position_value_i;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

### sv/srg_arith.sv
// ----------------------------------------------------------------------------
// srg_arith: iterative multiply and divide unit
// Shift-add multiply (48 steps) and restoring divide (64 steps).
// ----------------------------------------------------------------------------
module srg_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srg_pkg::arith_req_t  req_i,
  input  logic [47:0]          mul_a_i,
  input  logic [63:0]          div_num_i,
  input  logic [33:0]          div_den_i,
  output logic                 done_o,
  output logic [95:0]          prod_o,
  output logic [63:0]          quot_o
);
  import srg_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  arith_op_e   op_q;
  logic [95:0] p_q;
  logic [47:0] mcand_q;
  logic [63:0] quot_q;
  logic [33:0] rem_q, den_q;

  logic [48:0] mul_sum;
  logic [34:0] trial;
  logic        ge;

  assign mul_sum = {1'b0, p_q[95:48]} + (p_q[0] ? {1'b0, mcand_q} : 49'd0);
  assign trial   = {rem_q, quot_q[63]};
  assign ge      = trial >= {1'b0, den_q};

  assign done_o = done_q;
  assign prod_o = p_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
      op_q   <= AR_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == AR_MUL) ? MUL_STEPS : DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      if (req_i.op == AR_MUL) begin
        p_q     <= {48'd0, mul_a_i};
        mcand_q <= mul_a_i;
      end else begin
        quot_q <= div_num_i;
        den_q  <= div_den_i;
        rem_q  <= 34'd0;
      end
    end else if (busy_q) begin
      if (op_q == AR_MUL) begin
        p_q <= {mul_sum, p_q[47:1]};
      end else begin
        rem_q  <= ge ? 34'(trial - {1'b0, den_q}) : trial[33:0];
        quot_q <= {quot_q[62:0], ge};
      end
    end
  end

endmodule

### sv/srg_back.sv
// ----------------------------------------------------------------------------
// srg_back: motion sequencer
// Executes queued requests, runs the ramp update and drives the result port.
// ----------------------------------------------------------------------------
module srg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 q_valid_i,
  input  srg_pkg::item_t       q_item_i,
  output logic                 q_pop_o,
  output srg_pkg::arith_req_t  ar_req_o,
  output logic [47:0]          ar_mul_a_o,
  output logic [63:0]          ar_div_num_o,
  output logic [33:0]          ar_div_den_o,
  input  logic                 ar_done_i,
  input  logic [95:0]          ar_prod_i,
  input  logic [63:0]          ar_quot_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 step_pulse_o,
  output logic                 dir_cw_o,
  output logic                 running_o,
  output logic signed [31:0]   position_now_o
);
  import srg_pkg::*;

  state_e state_q, state_d;

  logic [19:0] accel_q;
  logic [31:0] first_q, min_q;

  logic [31:0] position_q, target_q, ramp_q, interval_q, elapsed_q, sts_q;
  logic [23:0] active_q;
  logic        dir_q, step_q, stop_q, launched_q;
  logic [47:0] speed_q;

  logic        out_valid_q, out_step_q, out_dir_q, out_run_q;
  logic [31:0] out_pos_q;

  // Combinational helpers.
  logic [31:0] el_inc, pos_gap, abs_d, n_new, stop_tgt, first_cl, min_cl, new_int;
  logic [31:0] sts_sat, step_pos;
  logic        fire, dpos, dneg, dzero, sts_ge, zero_case, slot_free;
  logic [19:0] a_eff;
  logic [34:0] den;
  logic [33:0] mag, sum_int;

  assign el_inc   = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;
  assign fire     = (active_q != 24'd0) && (el_inc >= {8'd0, active_q});
  assign step_pos = dir_q ? position_q + 32'd1 : position_q - 32'd1;

  assign pos_gap = target_q - position_q;
  assign dzero   = (pos_gap == 32'd0);
  assign dneg    = pos_gap[31];
  assign dpos    = !dneg && !dzero;
  assign abs_d   = dneg ? 32'(-pos_gap) : pos_gap;
  assign sts_ge  = sts_q >= abs_d;
  assign zero_case = dzero && (sts_q <= 32'd1);

  always_comb begin
    n_new = ramp_q;
    if (dpos) begin
      if (!ramp_q[31] && ramp_q != 32'd0) begin
        if (sts_ge || !dir_q) n_new = 32'(-sts_q);
      end else if (ramp_q[31]) begin
        if (!sts_ge && dir_q) n_new = 32'(-ramp_q);
      end
    end else if (dneg) begin
      if (!ramp_q[31] && ramp_q != 32'd0) begin
        if (sts_ge || dir_q) n_new = 32'(-sts_q);
      end else if (ramp_q[31]) begin
        if (!sts_ge && !dir_q) n_new = 32'(-ramp_q);
      end
    end
  end

  assign stop_tgt = dir_q ? position_q + (sts_q + 32'd1) : position_q - (sts_q + 32'd1);
  assign a_eff    = (accel_q == 20'd0) ? 20'd1 : accel_q;
  assign first_cl = (first_q < INTERVAL_FLOOR) ? INTERVAL_FLOOR : first_q;
  assign min_cl   = (min_q < INTERVAL_FLOOR) ? INTERVAL_FLOOR : min_q;
  assign sts_sat  = (ar_quot_i > {32'd0, STS_MAX}) ? STS_MAX : ar_quot_i[31:0];

  // Ramp denominator 4n+1 and its magnitude.
  assign den = {ramp_q[31], ramp_q, 2'b01};
  assign mag = den[34] ? 34'(-den) : den[33:0];

  always_comb begin
    sum_int = {2'b00, interval_q} + ar_quot_i[33:0];
    if (!ramp_q[31]) begin
      new_int = interval_q - ar_quot_i[31:0];
    end else if (sum_int[33:32] != 2'b00) begin
      new_int = 32'hFFFF_FFFF;
    end else begin
      new_int = sum_int[31:0];
    end
    if (new_int < min_cl) begin
      new_int = min_cl;
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_item_i.op)
            OP_TICK:   state_d = fire ? ST_STS_MUL : ST_EMIT;
            OP_MOVE:   state_d = (q_item_i.value != target_q) ? ST_STS_MUL : ST_EMIT;
            OP_SETPOS: state_d = ST_EMIT;
            OP_STOP:   state_d = (speed_q != 48'd0) ? ST_STS_MUL : ST_EMIT;
            default:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_STS_MUL: if (ar_done_i) state_d = ST_STS_DIV;
      ST_STS_DIV: if (ar_done_i) state_d = stop_q ? ST_STOP : ST_DECIDE;
      ST_STOP:    state_d = (stop_tgt != target_q) ? ST_STS_MUL : ST_EMIT;
      ST_DECIDE: begin
        if (zero_case) begin
          state_d = ST_EMIT;
        end else if (n_new == 32'd0) begin
          state_d = ST_SPEED;
        end else begin
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: if (ar_done_i) state_d = ST_SPEED;
      ST_SPEED: if (ar_done_i) state_d = ST_EMIT;
      ST_EMIT:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Arithmetic unit requests.
  always_comb begin
    ar_req_o.start = 1'b0;
    ar_req_o.op    = AR_DIV;
    ar_mul_a_o     = speed_q;
    ar_div_num_o   = SPEED_NUM;
    ar_div_den_o   = {2'b00, interval_q};
    unique case (state_q)
      ST_STS_MUL: begin
        ar_req_o.start = !launched_q;
        ar_req_o.op    = AR_MUL;
      end
      ST_STS_DIV: begin
        ar_req_o.start = !launched_q;
        ar_div_num_o   = ar_prod_i[95:32];
        ar_div_den_o   = {13'd0, a_eff, 1'b0};
      end
      ST_DELTA: begin
        ar_req_o.start = !launched_q;
        ar_div_num_o   = {31'd0, interval_q, 1'b0};
        ar_div_den_o   = mag;
      end
      ST_SPEED: begin
        ar_req_o.start = !launched_q;
      end
      default: ar_req_o.start = 1'b0;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign step_pulse_o   = out_step_q;
  assign dir_cw_o       = out_dir_q;
  assign running_o      = out_run_q;
  assign position_now_o = out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      accel_q     <= 20'd1;
      first_q     <= 32'd244738048;
      min_q       <= 32'd256000000;
      position_q  <= 32'd0;
      target_q    <= 32'd0;
      ramp_q      <= 32'd0;
      interval_q  <= 32'd0;
      active_q    <= 24'd0;
      elapsed_q   <= 32'd0;
      dir_q       <= 1'b0;
      speed_q     <= 48'd0;
      sts_q       <= 32'd0;
      step_q      <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        launched_q <= 1'b0;
      end else if (ar_req_o.start) begin
        launched_q <= 1'b1;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ACCEL:     accel_q <= cfg_data_i[19:0];
          CFG_FIRST_INT: first_q <= cfg_data_i;
          CFG_MIN_INT:   min_q   <= cfg_data_i;
          default:       ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            step_q <= 1'b0;
            stop_q <= 1'b0;
            unique case (q_item_i.op)
              OP_TICK: begin
                if (fire) begin
                  position_q <= step_pos;
                  elapsed_q  <= 32'd0;
                  step_q     <= 1'b1;
                end else begin
                  elapsed_q <= el_inc;
                end
              end
              OP_MOVE: target_q <= q_item_i.value;
              OP_SETPOS: begin
                position_q <= q_item_i.value;
                target_q   <= q_item_i.value;
                ramp_q     <= 32'd0;
                active_q   <= 24'd0;
                speed_q    <= 48'd0;
              end
              OP_STOP: stop_q <= (speed_q != 48'd0);
              default: ;
            endcase
          end
        end
        ST_STS_DIV: if (ar_done_i) sts_q <= sts_sat;
        ST_STOP: begin
          stop_q   <= 1'b0;
          target_q <= stop_tgt;
        end
        ST_DECIDE: begin
          if (zero_case) begin
            active_q <= 24'd0;
            speed_q  <= 48'd0;
            ramp_q   <= 32'd0;
          end else if (n_new == 32'd0) begin
            interval_q <= first_cl;
            dir_q      <= dpos;
            ramp_q     <= 32'd1;
          end else begin
            ramp_q <= n_new;
          end
        end
        ST_DELTA: begin
          if (ar_done_i) begin
            interval_q <= new_int;
            if (ramp_q != RAMP_MAX) ramp_q <= ramp_q + 32'd1;
          end
        end
        ST_SPEED: begin
          if (ar_done_i) begin
            speed_q  <= ar_quot_i[47:0];
            active_q <= interval_q[31:8];
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase

      if (!(state_q == ST_EMIT && slot_free) && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && slot_free) begin
      out_step_q <= step_q;
      out_dir_q  <= dir_q;
      out_run_q  <= (speed_q != 48'd0) || (target_q != position_q);
      out_pos_q  <= position_q;
    end
  end

endmodule

### sv/stepper_trapezoid_ramp_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_generator_core: trapezoidal stepper speed profile
// Turns tick, move, set-position and stop requests into step pulses.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid_i/in_stall_o  opcode_i, position_value_i
//  result    out_valid_o/out_stall_i step_pulse_o, dir_cw_o, running_o,
//                                   position_now_o
//  config    cfg_we_i               cfg_index_i, cfg_data_i
//
// A tick without a step, a set-position and an ignored move or stop pass
// through the queue and then the sequencer's dispatch and result-write
// states. A request that recomputes the ramp runs the shared multiply/divide
// unit: one squaring, then up to three divisions (stop distance, ramp delta,
// speed); a stop request adds one more squaring and division. Reset clears
// all motion state at once. The two-entry request queue keeps accepting
// until it is full while the result register waits on out_stall_i.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_generator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] position_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               step_pulse_o,
  output logic               dir_cw_o,
  output logic               running_o,
  output logic signed [31:0] position_now_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import srg_pkg::*;

  logic        q_valid, q_pop;
  item_t       q_item;
  arith_req_t  ar_req;
  logic [47:0] ar_mul_a;
  logic [63:0] ar_div_num, ar_quot;
  logic [33:0] ar_div_den;
  logic [95:0] ar_prod;
  logic        ar_done;

  // The front end decodes requests and buffers them.
  srg_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .position_value_i (position_value_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  // The sequencer owns all motion state and the result register.
  srg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .ar_req_o       (ar_req),
    .ar_mul_a_o     (ar_mul_a),
    .ar_div_num_o   (ar_div_num),
    .ar_div_den_o   (ar_div_den),
    .ar_done_i      (ar_done),
    .ar_prod_i      (ar_prod),
    .ar_quot_i      (ar_quot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_pulse_o   (step_pulse_o),
    .dir_cw_o       (dir_cw_o),
    .running_o      (running_o),
    .position_now_o (position_now_o)
  );

  // One shared iterative unit does every multiply and divide of the ramp.
  srg_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ar_req),
    .mul_a_i   (ar_mul_a),
    .div_num_i (ar_div_num),
    .div_den_i (ar_div_den),
    .done_o    (ar_done),
    .prod_o    (ar_prod),
    .quot_o    (ar_quot)
  );

endmodule

### sv/srg_checker.sv
// ----------------------------------------------------------------------------
// srg_checker: port-level checks of the ramp generator
// Tracks outstanding requests and checks the result channel against them.
// ----------------------------------------------------------------------------
module srg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] position_now_o
);
  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else begin
      pending_q <= pending_q + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  // A result is only shown for a request that was taken.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0) else $error("result without request");

  // Input backpressure only while requests are outstanding.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pending_q != 4'd0) else $error("stall while empty");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("valid dropped");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(position_now_o))
    else $error("stalled position changed");

endmodule

bind stepper_trapezoid_ramp_generator_core srg_checker u_srg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .position_now_o (position_now_o)
);
